// File: rtl/psd_pkg.sv
// psd_pkg: shared types and constants for the parity steered deque.
// Item structs, command and status codes, default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    localparam int DEF_MAX_SLOTS = 128;
    localparam int CAP_W         = 8;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        command_t           command;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        status_t            status;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/parity_steered_deque.sv
// parity_steered_deque: circular deque of signed words, odd inserts at the
// front, even inserts at the rear, reads remove from the front.
// Depends on psd_pkg and psd_slot_ram.
//
// Usage:
//   s_valid/s_ready/s_item carry commands (insert or read), m_valid/m_ready/
//   m_item carry exactly one result item per command (data and status).
//   cfg_wr_en/cfg_wr_data set the capacity (1..MAX_SLOTS, 0 acts as 1, larger
//   values clamp) and empty the queue; write only while the block is idle.
//   An insert or a refused read gives its result in the cycle after acceptance;
//   a successful read gives it from the output register once the registered
//   read data of the slot store is there. Inserts may be taken every cycle, a
//   read holds off the next item for one extra cycle while the store is read.
//   A result waiting in the output register does not block acceptance as
//   long as it is taken in the same cycle; while m_ready is low and a
//   result is held, s_ready stays low.
//   After reset the queue is empty, the capacity is 128 and no result is
//   pending; the slot store is not cleared, no unwritten slot is ever read.
`timescale 1ns / 1ps
`default_nettype none

module parity_steered_deque #(
    parameter int MAX_SLOTS = psd_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [psd_pkg::CAP_W-1:0]    cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire psd_pkg::in_item_t            s_item,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output psd_pkg::out_item_t                m_item
);
    import psd_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int LW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;

    typedef enum logic {
        S_IDLE,
        S_READ_WAIT
    } state_t;

    state_t            state_reg;
    logic [CAP_W-1:0]  capacity_reg;
    logic [IW-1:0]     front_reg, front_next;
    logic [IW-1:0]     rear_reg, rear_next;
    logic              empty_reg, empty_next;
    logic              m_valid_reg;
    out_item_t         m_item_reg;

    logic [LW-1:0]     live_cap;
    logic [LW-1:0]     rear_inc, front_inc;
    logic [IW-1:0]     rear_wrap, front_wrap;
    logic [IW-1:0]     front_dec;
    logic              full;
    logic              accept;
    logic              is_read;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic              rd_en;
    logic signed [31:0] rd_data;
    status_t           status_now;

    always_comb begin
        if (capacity_reg == '0) begin
            live_cap = LW'(1);
        end else if (LW'(capacity_reg) > LW'(MAX_SLOTS)) begin
            live_cap = LW'(MAX_SLOTS);
        end else begin
            live_cap = LW'(capacity_reg);
        end
    end

    assign rear_inc   = LW'(rear_reg) + LW'(1);
    assign front_inc  = LW'(front_reg) + LW'(1);
    assign rear_wrap  = (rear_inc >= live_cap) ? '0 : rear_inc[IW-1:0];
    assign front_wrap = (front_inc >= live_cap) ? '0 : front_inc[IW-1:0];
    assign front_dec  = (front_reg == '0) ? IW'(live_cap - LW'(1))
                                          : front_reg - IW'(1);
    assign full       = !empty_reg && (rear_wrap == front_reg);

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign is_read = (s_item.command == CMD_READ);

    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        empty_next = empty_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        status_now = ST_OK;
        if (accept) begin
            if (!is_read) begin
                priority if (full) begin
                    status_now = ST_FULL;
                end else if (empty_reg) begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end else if (s_item.value[0]) begin
                    front_next = front_dec;
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                end else begin
                    rear_next  = rear_wrap;
                    wr_en      = 1'b1;
                    wr_addr    = rear_wrap;
                end
            end else begin
                if (empty_reg) begin
                    status_now = ST_EMPTY;
                end else begin
                    rd_en = 1'b1;
                    if (front_reg == rear_reg) begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b1;
                    end else begin
                        front_next = front_wrap;
                    end
                end
            end
        end
    end

    psd_slot_ram #(
        .MAX_SLOTS (MAX_SLOTS),
        .IW        (IW)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_item.value),
        .rd_en   (rd_en),
        .rd_addr (front_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            capacity_reg <= CAP_RESET;
            front_reg    <= '0;
            rear_reg     <= '0;
            empty_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
                front_reg    <= '0;
                rear_reg     <= '0;
                empty_reg    <= 1'b1;
            end else begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                empty_reg <= empty_next;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept && rd_en) begin
                        state_reg   <= S_READ_WAIT;
                        m_valid_reg <= 1'b0;
                    end else if (accept) begin
                        m_valid_reg          <= 1'b1;
                        m_item_reg.read_data <= '0;
                        m_item_reg.status    <= status_now;
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                S_READ_WAIT: begin
                    // output register was freed when the read was taken
                    m_valid_reg          <= 1'b1;
                    m_item_reg.read_data <= rd_data;
                    m_item_reg.status    <= ST_OK;
                    state_reg            <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// File: rtl/psd_slot_ram.sv
// psd_slot_ram: slot store of the deque, one write and one read port.
// Read data registered.
// Depends on psd_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module psd_slot_ram #(
    parameter int MAX_SLOTS = psd_pkg::DEF_MAX_SLOTS,
    parameter int IW        = $clog2(MAX_SLOTS)
) (
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [IW-1:0]       wr_addr,
    input  wire logic signed [31:0]  wr_data,
    input  wire logic                rd_en,
    input  wire logic [IW-1:0]       rd_addr,
    output logic signed [31:0]       rd_data
);
    import psd_pkg::*;

    logic signed [31:0] mem [MAX_SLOTS];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for parity_steered_deque, directed then random
// command streams under bursty input and a stalling receiver, checked per item.
// Depends on psd_pkg and the parity_steered_deque RTL.

module testbench;
    import psd_pkg::*;

    localparam int SLOTS = DEF_MAX_SLOTS;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]   cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_item = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_item;

    always #4 aclk = ~aclk;

    parity_steered_deque u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    // shadow deque
    logic [CAP_W-1:0]   cap_setting = CAP_RESET;
    logic [31:0]        words [SLOTS];
    int                 head_idx = 0;
    int                 tail_idx = 0;
    bit                 is_vacant = 1'b1;

    in_item_t           pending_cmds[$];
    out_item_t          expected_results[$];
    out_item_t          want;
    int                 items_total = 0;
    int                 results_seen = 0;
    int                 err_count = 0;

    int                 burst_left = 1;
    int                 gap_left = 0;
    bit                 hold_req = 1'b0;
    bit                 hold_done = 1'b0;
    int                 hold_cnt = 0;
    logic [15:0]        ready_pat = 16'hFFFF;
    logic [5:0]         pat_cnt = '0;

    function automatic int live_cap();
        if (cap_setting == 0)
            return 1;
        if (cap_setting > SLOTS)
            return SLOTS;
        return int'(cap_setting);
    endfunction

    function automatic out_item_t deque_result(in_item_t it);
        out_item_t r;
        int        cap;
        int        next_tail;
        cap = live_cap();
        r.read_data = '0;
        r.status = ST_OK;
        if (it.command == CMD_INSERT) begin
            next_tail = (tail_idx + 1 >= cap) ? 0 : tail_idx + 1;
            if (!is_vacant && next_tail == head_idx) begin
                r.status = ST_FULL;
            end else if (is_vacant) begin
                head_idx = 0;
                tail_idx = 0;
                is_vacant = 1'b0;
                words[0] = it.value;
            end else if (it.value[0]) begin
                head_idx = (head_idx == 0) ? cap - 1 : head_idx - 1;
                words[head_idx] = it.value;
            end else begin
                tail_idx = next_tail;
                words[tail_idx] = it.value;
            end
        end else begin
            if (is_vacant) begin
                r.status = ST_EMPTY;
            end else begin
                r.read_data = words[head_idx];
                if (head_idx == tail_idx) begin
                    head_idx = 0;
                    tail_idx = 0;
                    is_vacant = 1'b1;
                end else begin
                    head_idx = (head_idx + 1 >= cap) ? 0 : head_idx + 1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("ERROR at %0t: %s got %h, expected %h", $realtime, what, got, exp_val);
        err_count++;
    endtask

    // sender: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(deque_result(s_item));
            if (s_valid && !s_ready) begin
                // item held until taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                s_valid <= 1'b1;
                s_item <= pending_cmds.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, reloaded each time the 6-bit pat_cnt wraps, plus one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 600;
            m_ready <= 1'b0;
        end else begin
            pat_cnt <= pat_cnt + 1'b1;
            m_ready <= ready_pat[0];
            if (pat_cnt == 0) begin
                case ($urandom_range(0, 2))
                    0:       ready_pat <= 16'hFFFF;
                    1:       ready_pat <= 16'($urandom);
                    default: ready_pat <= 16'($urandom & $urandom);
                endcase
            end else begin
                ready_pat <= {ready_pat[0], ready_pat[15:1]};
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result item with none expected", m_item.read_data, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_item.read_data !== want.read_data)
                    report_mismatch("read_data", m_item.read_data, want.read_data);
                if (m_item.status !== want.status)
                    report_mismatch("status", 32'(m_item.status), 32'(want.status));
            end
        end
    end

    task automatic push_cmd(input command_t c, input logic [31:0] v);
        in_item_t it;
        it.command = c;
        it.value = v;
        pending_cmds.push_back(it);
        items_total++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(input int n, input int insert_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < insert_pct)
                push_cmd(CMD_INSERT, pick_value());
            else
                push_cmd(CMD_READ, $urandom);
        end
    endtask

    task automatic drain();
        while (results_seen != items_total)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        cap_setting = v;
        head_idx = 0;
        tail_idx = 0;
        is_vacant = 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [CAP_W-1:0] caps [10];
        int               eff;
        foreach (words[i])
            words[i] = '0;
        caps = '{8'd3, 8'd255, 8'd1, 8'd128, 8'd16, 8'd200, 8'd2, 8'd0, 8'd64, 8'd50};
        caps[9] = CAP_W'($urandom_range(4, 100));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset capacity: wrap of the front pointer, value extremes, empty reads
        push_cmd(CMD_READ, 32'h0);
        push_cmd(CMD_INSERT, 32'h0000_0000);
        push_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        push_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        push_cmd(CMD_INSERT, 32'h8000_0000);
        push_cmd(CMD_INSERT, 32'h8000_0001);
        repeat (6) push_cmd(CMD_READ, 32'hFFFF_FFFF);
        drain();

        // zero capacity behaves as one slot
        set_capacity(8'd0);
        push_cmd(CMD_INSERT, 32'h5);
        push_cmd(CMD_INSERT, 32'h6);
        push_cmd(CMD_INSERT, 32'h3);
        push_cmd(CMD_READ, 32'h0);
        push_cmd(CMD_READ, 32'h0);
        drain();

        set_capacity(8'd2);
        push_cmd(CMD_INSERT, 32'hFFFF_FFFE);
        push_cmd(CMD_INSERT, 32'h1);
        push_cmd(CMD_INSERT, 32'hA);
        repeat (3) push_cmd(CMD_READ, 32'h0);
        drain();

        // fill, mix, drain at each capacity
        foreach (caps[i]) begin
            set_capacity(caps[i]);
            eff = (caps[i] == 0) ? 1 : (caps[i] > SLOTS) ? SLOTS : int'(caps[i]);
            if (i == 3)
                hold_req = 1'b1;
            queue_random(eff + 20, 95);
            queue_random(15, 50);
            queue_random(eff + 13, 10);
            drain();
        end

        repeat (8) @(posedge aclk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
